/* src/lhm_pkg.sv */
// shared types, constants and register map of the localization health monitor
package lhm_pkg;

   localparam int GEN_BITS = 8;
   localparam int AGE_BITS = 16;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 96;

   typedef enum logic [2:0] {
      KIND_POSE     = 3'd0,
      KIND_SCAN     = 3'd1,
      KIND_ODOM     = 3'd2,
      KIND_REPORT   = 3'd3,
      KIND_TICK     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_WAIT     = 3'd0,
      MODE_ALIGN    = 3'd1,
      MODE_LOCAL    = 3'd2,
      MODE_DEGRADED = 3'd3,
      MODE_LOST     = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      REG_MIN_INLIER    = 3'd0,
      REG_OVERLAP_FLOOR = 3'd1,
      REG_RMSE_LIMIT    = 3'd2,
      REG_GOOD_NEEDED   = 3'd3,
      REG_BAD_NEEDED    = 3'd4,
      REG_STALE_LIMIT   = 3'd5,
      REG_MATCH_TIMEOUT = 3'd6,
      REG_UNUSED        = 3'd7
   } reg_index_type;

   localparam logic [19:0] RST_MIN_INLIER    = 20'd100;
   localparam logic [16:0] RST_OVERLAP_FLOOR = 17'd19661;
   localparam logic [23:0] RST_RMSE_LIMIT    = 24'd22938;
   localparam logic [7:0]  RST_GOOD_NEEDED   = 8'd1;
   localparam logic [7:0]  RST_BAD_NEEDED    = 8'd3;
   localparam logic [15:0] RST_STALE_LIMIT   = 16'd20;
   localparam logic [15:0] RST_MATCH_TIMEOUT = 16'd100;

   localparam logic [7:0]          COUNT_MAX = 8'hFF;
   localparam logic [AGE_BITS-1:0] AGE_MAX   = {AGE_BITS{1'b1}};

   function automatic logic [7:0] count_up(input logic [7:0] c);
      logic [7:0] r;
      r = (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
      return r;
   endfunction

   function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
      logic [AGE_BITS-1:0] r;
      r = (a == AGE_MAX) ? AGE_MAX : a + {{(AGE_BITS-1){1'b0}}, 1'b1};
      return r;
   endfunction

endpackage

/* src/localization_health_monitor.sv */
// localization health monitor: mode and counter supervision of registration quality
// the result word is registered and is valid in the cycle after its request word is accepted
// throughput: one word per cycle, the whole event is one pass of update logic
//    between the state registers and the result register
// the result register frees as it is taken, so a stalled rsp side only holds req
// reset: synchronous, active high; clears mode, counters, ages and metrics, loads csr defaults
module localization_health_monitor
   import lhm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // csr port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   // request word
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // gen_tag[7:0], outcome[8], inlier_count[28:9], overlap[45:29],
   // rmse[69:46], rmse_finite[70], zero[71]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // kind[2:0]
   input  logic [2:0]               req_tuser,
   // result word
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // mode[2:0], good_count[10:3], bad_count[18:11], was_localized[19],
   // pose_applied[20], last_inliers[40:21], last_overlap[57:41],
   // last_rmse[81:58], last_rmse_finite[82], generation[90:83], zero[95:91]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // configuration registers
   logic [19:0] min_inlier_ff;
   logic [16:0] overlap_floor_ff;
   logic [23:0] rmse_limit_ff;
   logic [7:0]  good_needed_ff;
   logic [7:0]  bad_needed_ff;
   logic [15:0] stale_limit_ff;
   logic [15:0] match_timeout_ff;

   // monitor state
   mode_type            mode_ff, mode_in;
   logic [7:0]          good_ff, good_in;
   logic [7:0]          bad_ff, bad_in;
   logic                ever_ff, ever_in;
   logic                pose_ff, pose_in;
   logic [GEN_BITS-1:0] gen_ff, gen_in;
   logic [AGE_BITS-1:0] scan_age_ff, scan_age_in;
   logic [AGE_BITS-1:0] odom_age_ff, odom_age_in;
   logic [AGE_BITS-1:0] succ_age_ff, succ_age_in;
   logic                scan_seen_ff, scan_seen_in;
   logic                odom_seen_ff, odom_seen_in;
   logic                succ_seen_ff, succ_seen_in;
   logic [19:0]         m_inl_ff, m_inl_in;
   logic [16:0]         m_ovl_ff, m_ovl_in;
   logic [23:0]         m_rmse_ff, m_rmse_in;
   logic                m_fin_ff, m_fin_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic          csr_write;
   reg_index_type csr_index;
   logic          req_accept;
   kind_type      req_kind;
   logic [7:0]    in_tag;
   logic          in_outcome;
   logic [19:0]   in_inl;
   logic [16:0]   in_ovl;
   logic [23:0]   in_rmse;
   logic          in_fin;
   logic          passed;
   logic          stale;
   logic          expired;
   logic [7:0]    good_up;
   logic [7:0]    bad_up;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      case (csr_index)
         REG_MIN_INLIER:    csr_prdata = {12'd0, min_inlier_ff};
         REG_OVERLAP_FLOOR: csr_prdata = {15'd0, overlap_floor_ff};
         REG_RMSE_LIMIT:    csr_prdata = {8'd0, rmse_limit_ff};
         REG_GOOD_NEEDED:   csr_prdata = {24'd0, good_needed_ff};
         REG_BAD_NEEDED:    csr_prdata = {24'd0, bad_needed_ff};
         REG_STALE_LIMIT:   csr_prdata = {16'd0, stale_limit_ff};
         REG_MATCH_TIMEOUT: csr_prdata = {16'd0, match_timeout_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_inlier_ff    <= RST_MIN_INLIER;
         overlap_floor_ff <= RST_OVERLAP_FLOOR;
         rmse_limit_ff    <= RST_RMSE_LIMIT;
         good_needed_ff   <= RST_GOOD_NEEDED;
         bad_needed_ff    <= RST_BAD_NEEDED;
         stale_limit_ff   <= RST_STALE_LIMIT;
         match_timeout_ff <= RST_MATCH_TIMEOUT;
      end else if (csr_write) begin
         case (csr_index)
            REG_MIN_INLIER:    min_inlier_ff    <= csr_pwdata[19:0];
            REG_OVERLAP_FLOOR: overlap_floor_ff <= csr_pwdata[16:0];
            REG_RMSE_LIMIT:    rmse_limit_ff    <= csr_pwdata[23:0];
            REG_GOOD_NEEDED:   good_needed_ff   <= csr_pwdata[7:0];
            REG_BAD_NEEDED:    bad_needed_ff    <= csr_pwdata[7:0];
            REG_STALE_LIMIT:   stale_limit_ff   <= csr_pwdata[15:0];
            REG_MATCH_TIMEOUT: match_timeout_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // request side: free whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_kind   = kind_type'(req_tuser);
   assign in_tag     = req_tdata[7:0];
   assign in_outcome = req_tdata[8];
   assign in_inl     = req_tdata[28:9];
   assign in_ovl     = req_tdata[45:29];
   assign in_rmse    = req_tdata[69:46];
   assign in_fin     = req_tdata[70];

   assign passed = in_outcome && in_fin && (in_inl >= min_inlier_ff) &&
                   (in_ovl >= overlap_floor_ff) && (in_rmse <= rmse_limit_ff);
   assign good_up = count_up(good_ff);
   assign bad_up  = count_up(bad_ff);

   // ages as they stand after a tick
   always_comb begin
      stale   = (scan_seen_ff && 32'(age_up(scan_age_ff)) > 32'(stale_limit_ff)) ||
                (odom_seen_ff && 32'(age_up(odom_age_ff)) > 32'(stale_limit_ff));
      expired = ever_ff && succ_seen_ff &&
                (32'(age_up(succ_age_ff)) > 32'(match_timeout_ff));
   end

   always_comb begin
      mode_in      = mode_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      ever_in      = ever_ff;
      pose_in      = pose_ff;
      gen_in       = gen_ff;
      scan_age_in  = scan_age_ff;
      odom_age_in  = odom_age_ff;
      succ_age_in  = succ_age_ff;
      scan_seen_in = scan_seen_ff;
      odom_seen_in = odom_seen_ff;
      succ_seen_in = succ_seen_ff;
      m_inl_in     = m_inl_ff;
      m_ovl_in     = m_ovl_ff;
      m_rmse_in    = m_rmse_ff;
      m_fin_in     = m_fin_ff;
      case (req_kind)
         KIND_POSE: begin
            // a pose before any odometry is dropped
            if (odom_seen_ff) begin
               pose_in      = 1'b1;
               ever_in      = 1'b0;
               mode_in      = MODE_ALIGN;
               good_in      = '0;
               bad_in       = '0;
               m_inl_in     = '0;
               m_ovl_in     = '0;
               m_rmse_in    = '0;
               m_fin_in     = 1'b0;
               succ_seen_in = 1'b0;
               succ_age_in  = '0;
               gen_in       = gen_ff + {{(GEN_BITS-1){1'b0}}, 1'b1};
            end
         end
         KIND_SCAN: begin
            scan_seen_in = 1'b1;
            scan_age_in  = '0;
         end
         KIND_ODOM: begin
            odom_seen_in = 1'b1;
            odom_age_in  = '0;
         end
         KIND_REPORT: begin
            if (pose_ff && scan_seen_ff && in_tag == 8'(gen_ff)) begin
               if (in_outcome) begin
                  m_inl_in  = in_inl;
                  m_ovl_in  = in_ovl;
                  m_fin_in  = in_fin;
                  m_rmse_in = in_fin ? in_rmse : '0;
               end else begin
                  m_inl_in  = '0;
                  m_ovl_in  = '0;
                  m_rmse_in = '0;
                  m_fin_in  = 1'b0;
               end
               if (passed) begin
                  good_in      = good_up;
                  bad_in       = '0;
                  succ_seen_in = 1'b1;
                  succ_age_in  = '0;
                  if (good_up >= good_needed_ff) begin
                     mode_in = MODE_LOCAL;
                     ever_in = 1'b1;
                  end else begin
                     mode_in = MODE_ALIGN;
                  end
               end else begin
                  good_in = '0;
                  bad_in  = bad_up;
                  if (bad_up >= bad_needed_ff) mode_in = MODE_LOST;
                  else mode_in = ever_ff ? MODE_DEGRADED : MODE_ALIGN;
               end
            end
         end
         KIND_TICK: begin
            scan_age_in = age_up(scan_age_ff);
            odom_age_in = age_up(odom_age_ff);
            succ_age_in = age_up(succ_age_ff);
            if (pose_ff && (stale || expired)) mode_in = MODE_LOST;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = {5'd0, 8'(gen_in), m_fin_in, m_rmse_in, m_ovl_in, m_inl_in,
                      pose_in, ever_in, bad_in, good_in, mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         good_ff      <= '0;
         bad_ff       <= '0;
         ever_ff      <= 1'b0;
         pose_ff      <= 1'b0;
         gen_ff       <= '0;
         scan_age_ff  <= '0;
         odom_age_ff  <= '0;
         succ_age_ff  <= '0;
         scan_seen_ff <= 1'b0;
         odom_seen_ff <= 1'b0;
         succ_seen_ff <= 1'b0;
         m_inl_ff     <= '0;
         m_ovl_ff     <= '0;
         m_rmse_ff    <= '0;
         m_fin_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            mode_ff      <= mode_in;
            good_ff      <= good_in;
            bad_ff       <= bad_in;
            ever_ff      <= ever_in;
            pose_ff      <= pose_in;
            gen_ff       <= gen_in;
            scan_age_ff  <= scan_age_in;
            odom_age_ff  <= odom_age_in;
            succ_age_ff  <= succ_age_in;
            scan_seen_ff <= scan_seen_in;
            odom_seen_ff <= odom_seen_in;
            succ_seen_ff <= succ_seen_in;
            m_inl_ff     <= m_inl_in;
            m_ovl_ff     <= m_ovl_in;
            m_rmse_ff    <= m_rmse_in;
            m_fin_ff     <= m_fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // good and bad runs exclude each other
   a_runs_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[10:3] == 8'd0 || rsp_data_ff[18:11] == 8'd0))
      else $error("good and bad counts both nonzero");

   // leaving the waiting mode needs a pose
   a_mode_needs_pose: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_WAIT |-> pose_ff)
      else $error("mode left waiting without a pose");

   a_ever_needs_pose: assert property (@(posedge clock) disable iff (reset)
      ever_ff |-> pose_ff)
      else $error("localized flag set without a pose");

   // every accepted word yields a result in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");
`endif

endmodule
